>>> src/scpch_pkg.sv
// ----------------------------------------------------------------------------
// Purse command handler package
// Shared types, protocol constants and constant tables for the T=0 purse
// command handler.
// ----------------------------------------------------------------------------
package scpch_pkg;

   // Default number of personalization bytes the card stores.
   localparam int PERSO_BYTES_DEF = 32;

   // Class byte accepted after reset.
   localparam logic [7:0] CLASS_RESET = 8'h81;

   // Status word bytes.
   localparam logic [7:0] SW1_OK        = 8'h90;
   localparam logic [7:0] SW1_WRONG_LEN = 8'h6C;
   localparam logic [7:0] SW1_REFUSED   = 8'h61;
   localparam logic [7:0] SW1_BAD_INS   = 8'h6D;
   localparam logic [7:0] SW1_BAD_CLA   = 8'h6E;
   localparam logic [7:0] SW2_NONE      = 8'h00;

   // Instruction codes.
   localparam logic [7:0] INS_VERSION      = 8'd0;
   localparam logic [7:0] INS_WRITE_PERSO  = 8'd1;
   localparam logic [7:0] INS_READ_PERSO   = 8'd2;
   localparam logic [7:0] INS_READ_BALANCE = 8'd3;
   localparam logic [7:0] INS_CREDIT       = 8'd4;
   localparam logic [7:0] INS_DEBIT        = 8'd5;

   // Fixed lengths.
   localparam logic [7:0] VERSION_LEN = 8'd4;
   localparam logic [7:0] BALANCE_LEN = 8'd2;
   localparam logic [7:0] AMOUNT_LEN  = 8'd2;
   localparam logic [5:0] ATR_LAST    = 6'd12;
   localparam logic [2:0] HDR_LAST    = 3'd4;

   // Command phase of the card.
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_PERSO  = 2'd1,
      PH_AMOUNT = 2'd2
   } phase_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISP,
      ST_CHK,
      ST_PCHK,
      ST_ACHK,
      ST_ATR,
      ST_PROC,
      ST_FETCH,
      ST_DATA,
      ST_SW1,
      ST_SW2
   } state_type;

   // Source of the data bytes of a response.
   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_VERSION,
      SRC_PERSO,
      SRC_BALANCE
   } data_src_type;

   // Operation of the shared arithmetic unit.
   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   // Request to the shared arithmetic unit.
   typedef struct packed {
      alu_op_type  op;
      logic [15:0] a;
      logic [15:0] b;
   } alu_req_type;

   // Answer to reset: TS, T0, interface bytes, then the card name.
   function automatic logic [7:0] atr_byte(input logic [3:0] idx);
      logic [7:0] val;
      unique case (idx)
         4'd0:    val = 8'h3B;
         4'd1:    val = 8'hF7;
         4'd2:    val = 8'h01;
         4'd3:    val = 8'h05;
         4'd4:    val = 8'h05;
         4'd5:    val = 8'h00;
         4'd6:    val = 8'h00;
         4'd7:    val = 8'h62;
         4'd8:    val = 8'h6F;
         4'd9:    val = 8'h75;
         4'd10:   val = 8'h72;
         4'd11:   val = 8'h73;
         4'd12:   val = 8'h65;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   // Version string "1.00".
   function automatic logic [7:0] version_byte(input logic [1:0] idx);
      logic [7:0] val;
      unique case (idx)
         2'd0:    val = 8'h31;
         2'd1:    val = 8'h2E;
         default: val = 8'h30;
      endcase
      return val;
   endfunction

endpackage

>>> src/scpch_if.sv
// ----------------------------------------------------------------------------
// Purse command handler channels
// Valid/ready channels for received events and for transmitted bytes.
// ----------------------------------------------------------------------------

// Received event: a byte from the reader or a card reset.
interface scpch_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] rx_byte;

   modport source (output valid, output action, output rx_byte, input ready);
   modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

// Transmitted byte with an end-of-run flag.
interface scpch_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       last_of_run;

   modport source (output valid, output tx_byte, output last_of_run, input ready);
   modport sink   (input valid, input tx_byte, input last_of_run, output ready);
endinterface

>>> src/scpch_alu.sv
// ----------------------------------------------------------------------------
// Purse command handler arithmetic unit
// Shared 16-bit add/subtract unit with a registered 17-bit result. Bit 16
// is the carry of an add or the borrow of a subtract.
// ----------------------------------------------------------------------------
module scpch_alu (
   input  logic                  clock,
   input  scpch_pkg::alu_req_type alu_req,
   output logic [16:0]           alu_res
);

   logic [16:0] res_ff;
   logic [16:0] res_in;

   // Add or subtract with one extra bit for carry or borrow.
   always_comb begin
      unique case (alu_req.op)
         scpch_pkg::ALU_ADD: res_in = {1'b0, alu_req.a} + {1'b0, alu_req.b};
         default:            res_in = {1'b0, alu_req.a} - {1'b0, alu_req.b};
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign alu_res = res_ff;

endmodule

>>> src/scpch_perso_mem.sv
// ----------------------------------------------------------------------------
// Purse command handler personalization memory
// Two banks of personalization bytes, one write port and one registered
// read port. One bank holds the committed data, the other one collects.
// ----------------------------------------------------------------------------
module scpch_perso_mem #(
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/smart_card_purse_command_handler_top.sv
// ----------------------------------------------------------------------------
// Smart card purse command handler
// Card side of a T=0 exchange for an electronic purse.
// ----------------------------------------------------------------------------
// Usage:
// The req_chan channel carries one event per transaction: a byte received
// from the reader (action low) or a card reset (action high). The rsp_chan
// channel carries the bytes to send, with last_of_run set on the final byte
// that an event produces. The class byte register is written through
// csr_wr_en/csr_wr_data; the user writes it only while the block is idle,
// as the block does not enforce this. A small sequencer drives a shared
// 16-bit add/subtract unit for length checks and balance updates, and walks
// the response byte by byte; each personalization byte read back takes a
// memory read, then a send. A completed header passes the class/instruction
// check and the length check before any byte is sent; credit and debit pass
// an arithmetic check before the status word. A card reset sends the ATR.
// req_chan.ready is high only while the sequencer waits for an event.
// A stall on rsp_chan holds the output register and pauses the sending states.
// Synchronous reset restores the class byte, clears the balance and the
// personalization length and restarts header collection; no clearing pass.
// ----------------------------------------------------------------------------
module smart_card_purse_command_handler_top #(
   parameter int PERSO_BYTES = scpch_pkg::PERSO_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   scpch_req_if.sink         req_chan,
   scpch_rsp_if.source       rsp_chan,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data
);

   localparam int AW     = (PERSO_BYTES > 1) ? $clog2(PERSO_BYTES) : 1;
   localparam int MEM_AW = AW + 1;

   // Sequencer and command state.
   scpch_pkg::state_type    state_ff, state_in;
   scpch_pkg::phase_type    phase_ff, phase_in;
   logic [5:0]              bc_ff, bc_in;
   logic [7:0]              hdr_ff [5];
   logic [7:0]              hdr_in [5];
   logic [7:0]              amount_low_ff, amount_low_in;
   logic [15:0]             balance_ff, balance_in;
   logic [5:0]              perso_len_ff, perso_len_in;
   logic                    bank_ff, bank_in;
   logic [7:0]              class_ff, class_in;

   // Response description.
   logic [5:0]              emit_idx_ff, emit_idx_in;
   logic [5:0]              data_cnt_ff, data_cnt_in;
   scpch_pkg::data_src_type data_src_ff, data_src_in;
   logic                    has_sw_ff, has_sw_in;
   logic [7:0]              sw1_ff, sw1_in;
   logic [7:0]              sw2_ff, sw2_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_byte_ff, rsp_byte_in;
   logic                    rsp_last_ff, rsp_last_in;

   // Shared unit and memory connections.
   scpch_pkg::alu_req_type  alu_req;
   logic [16:0]             alu_res;
   logic                    mem_wr_en;
   logic [MEM_AW-1:0]       mem_wr_addr;
   logic                    mem_rd_en;
   logic [MEM_AW-1:0]       mem_rd_addr;
   logic [7:0]              mem_rd_data;

   // Decoded conditions.
   logic                    req_fire;
   logic                    out_free;
   logic [2:0]              hdr_pos;
   logic [7:0]              ins;
   logic [7:0]              p3;
   logic                    cls_ok;
   logic                    ins_known;
   logic [5:0]              bc_inc;
   logic [5:0]              emit_inc;
   logic                    alu_ge;
   logic                    alu_eq;
   logic                    len_fail;
   logic                    perso_done;
   logic                    data_last;
   logic [7:0]              data_byte;

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign hdr_pos    = (bc_ff >= 6'd5) ? 3'd0 : bc_ff[2:0];
   assign ins        = hdr_ff[1];
   assign p3         = hdr_ff[4];
   assign cls_ok     = (hdr_ff[0] == class_ff);
   assign ins_known  = (ins <= scpch_pkg::INS_DEBIT);
   assign bc_inc     = bc_ff + 6'd1;
   assign emit_inc   = emit_idx_ff + 6'd1;
   assign alu_ge     = !alu_res[16];
   assign alu_eq     = alu_ge && (alu_res[15:0] == 16'd0);
   assign len_fail   = (ins == scpch_pkg::INS_WRITE_PERSO) ? !alu_ge : !alu_eq;
   assign perso_done = alu_ge || (bc_ff == 6'd0);
   assign data_last  = (emit_inc == data_cnt_ff);

   assign req_chan.ready = (state_ff == scpch_pkg::ST_IDLE);

   // Data byte of the response being sent.
   always_comb begin
      unique case (data_src_ff)
         scpch_pkg::SRC_VERSION: data_byte = scpch_pkg::version_byte(emit_idx_ff[1:0]);
         scpch_pkg::SRC_PERSO:   data_byte = mem_rd_data;
         scpch_pkg::SRC_BALANCE: data_byte = emit_idx_ff[0] ? balance_ff[15:8]
                                                            : balance_ff[7:0];
         default:                data_byte = 8'h00;
      endcase
   end

   // Operands of the shared unit: length checks and balance updates.
   always_comb begin
      alu_req.op = scpch_pkg::ALU_SUB;
      alu_req.a  = 16'd0;
      alu_req.b  = 16'd0;
      priority if (state_ff == scpch_pkg::ST_IDLE && phase_ff == scpch_pkg::PH_PERSO) begin
         alu_req.a = {10'd0, bc_inc};
         alu_req.b = {8'd0, p3};
      end else if (state_ff == scpch_pkg::ST_IDLE && phase_ff == scpch_pkg::PH_AMOUNT) begin
         alu_req.op = (ins == scpch_pkg::INS_CREDIT) ? scpch_pkg::ALU_ADD
                                                     : scpch_pkg::ALU_SUB;
         alu_req.a  = balance_ff;
         alu_req.b  = {req_chan.rx_byte, amount_low_ff};
      end else if (state_ff == scpch_pkg::ST_DISP) begin
         priority if (ins == scpch_pkg::INS_VERSION) begin
            alu_req.a = {8'd0, p3};
            alu_req.b = {8'd0, scpch_pkg::VERSION_LEN};
         end else if (ins == scpch_pkg::INS_WRITE_PERSO) begin
            alu_req.a = 16'(PERSO_BYTES);
            alu_req.b = {8'd0, p3};
         end else if (ins == scpch_pkg::INS_READ_PERSO) begin
            alu_req.a = {8'd0, p3};
            alu_req.b = {10'd0, perso_len_ff};
         end else begin
            alu_req.a = {8'd0, p3};
            alu_req.b = {8'd0, scpch_pkg::AMOUNT_LEN};
         end
      end else begin
         alu_req.a = 16'd0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scpch_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.action) begin
                  state_in = scpch_pkg::ST_ATR;
               end else begin
                  unique case (phase_ff)
                     scpch_pkg::PH_PERSO:  state_in = scpch_pkg::ST_PCHK;
                     scpch_pkg::PH_AMOUNT: state_in = (bc_ff == 6'd0) ? scpch_pkg::ST_IDLE
                                                                      : scpch_pkg::ST_ACHK;
                     default:              state_in = (hdr_pos == scpch_pkg::HDR_LAST)
                                                      ? scpch_pkg::ST_DISP
                                                      : scpch_pkg::ST_IDLE;
                  endcase
               end
            end
         end
         scpch_pkg::ST_DISP: begin
            state_in = (!cls_ok || !ins_known) ? scpch_pkg::ST_SW1 : scpch_pkg::ST_CHK;
         end
         scpch_pkg::ST_CHK: begin
            state_in = len_fail ? scpch_pkg::ST_SW1 : scpch_pkg::ST_PROC;
         end
         scpch_pkg::ST_PCHK: begin
            state_in = perso_done ? scpch_pkg::ST_SW1 : scpch_pkg::ST_IDLE;
         end
         scpch_pkg::ST_ACHK: begin
            state_in = scpch_pkg::ST_SW1;
         end
         scpch_pkg::ST_ATR: begin
            if (out_free && emit_idx_ff == scpch_pkg::ATR_LAST) begin
               state_in = scpch_pkg::ST_IDLE;
            end
         end
         scpch_pkg::ST_PROC: begin
            if (out_free) begin
               priority if (data_cnt_ff != 6'd0) begin
                  state_in = (data_src_ff == scpch_pkg::SRC_PERSO) ? scpch_pkg::ST_FETCH
                                                                   : scpch_pkg::ST_DATA;
               end else if (has_sw_ff) begin
                  state_in = scpch_pkg::ST_SW1;
               end else begin
                  state_in = scpch_pkg::ST_IDLE;
               end
            end
         end
         scpch_pkg::ST_FETCH: begin
            state_in = scpch_pkg::ST_DATA;
         end
         scpch_pkg::ST_DATA: begin
            if (out_free) begin
               priority if (data_last) begin
                  state_in = has_sw_ff ? scpch_pkg::ST_SW1 : scpch_pkg::ST_IDLE;
               end else if (data_src_ff == scpch_pkg::SRC_PERSO) begin
                  state_in = scpch_pkg::ST_FETCH;
               end else begin
                  state_in = scpch_pkg::ST_DATA;
               end
            end
         end
         scpch_pkg::ST_SW1: begin
            if (out_free) begin
               state_in = scpch_pkg::ST_SW2;
            end
         end
         scpch_pkg::ST_SW2: begin
            if (out_free) begin
               state_in = scpch_pkg::ST_IDLE;
            end
         end
         default: state_in = scpch_pkg::ST_IDLE;
      endcase
   end

   // Datapath and output register updates.
   always_comb begin
      phase_in      = phase_ff;
      bc_in         = bc_ff;
      hdr_in        = hdr_ff;
      amount_low_in = amount_low_ff;
      balance_in    = balance_ff;
      perso_len_in  = perso_len_ff;
      bank_in       = bank_ff;
      class_in      = csr_wr_en ? csr_wr_data : class_ff;
      emit_idx_in   = emit_idx_ff;
      data_cnt_in   = data_cnt_ff;
      data_src_in   = data_src_ff;
      has_sw_in     = has_sw_ff;
      sw1_in        = sw1_ff;
      sw2_in        = sw2_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = {!bank_ff, bc_ff[AW-1:0]};
      mem_rd_en     = 1'b0;
      mem_rd_addr   = {bank_ff, emit_idx_ff[AW-1:0]};

      unique case (state_ff)
         scpch_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.action) begin
                  // Card reset: drop any open command and send the ATR.
                  phase_in    = scpch_pkg::PH_HEADER;
                  bc_in       = 6'd0;
                  emit_idx_in = 6'd0;
               end else begin
                  unique case (phase_ff)
                     scpch_pkg::PH_PERSO: begin
                        // Collect into the bank that is not committed.
                        mem_wr_en = (bc_ff < 6'(PERSO_BYTES));
                        bc_in     = bc_inc;
                     end
                     scpch_pkg::PH_AMOUNT: begin
                        if (bc_ff == 6'd0) begin
                           amount_low_in = req_chan.rx_byte;
                           bc_in         = 6'd1;
                        end
                     end
                     default: begin
                        phase_in         = scpch_pkg::PH_HEADER;
                        hdr_in[hdr_pos]  = req_chan.rx_byte;
                        bc_in            = (hdr_pos == scpch_pkg::HDR_LAST)
                                           ? 6'd0 : {3'd0, hdr_pos} + 6'd1;
                     end
                  endcase
               end
            end
         end
         scpch_pkg::ST_DISP: begin
            // Class and instruction check.
            sw2_in = scpch_pkg::SW2_NONE;
            sw1_in = cls_ok ? scpch_pkg::SW1_BAD_INS : scpch_pkg::SW1_BAD_CLA;
         end
         scpch_pkg::ST_CHK: begin
            // Length check result selects the response.
            emit_idx_in = 6'd0;
            data_cnt_in = 6'd0;
            data_src_in = scpch_pkg::SRC_NONE;
            has_sw_in   = 1'b1;
            sw1_in      = scpch_pkg::SW1_OK;
            sw2_in      = scpch_pkg::SW2_NONE;
            if (len_fail) begin
               sw1_in = scpch_pkg::SW1_WRONG_LEN;
               priority if (ins == scpch_pkg::INS_VERSION) begin
                  sw2_in = scpch_pkg::VERSION_LEN;
               end else if (ins == scpch_pkg::INS_WRITE_PERSO) begin
                  sw2_in = 8'(PERSO_BYTES);
               end else if (ins == scpch_pkg::INS_READ_PERSO) begin
                  sw2_in = {2'd0, perso_len_ff};
               end else begin
                  sw2_in = scpch_pkg::AMOUNT_LEN;
               end
            end else begin
               priority if (ins == scpch_pkg::INS_VERSION) begin
                  data_src_in = scpch_pkg::SRC_VERSION;
                  data_cnt_in = scpch_pkg::VERSION_LEN[5:0];
               end else if (ins == scpch_pkg::INS_WRITE_PERSO) begin
                  if (p3 == 8'd0) begin
                     // Empty write commits at once.
                     bank_in      = !bank_ff;
                     perso_len_in = 6'd0;
                  end else begin
                     phase_in  = scpch_pkg::PH_PERSO;
                     bc_in     = 6'd0;
                     has_sw_in = 1'b0;
                  end
               end else if (ins == scpch_pkg::INS_READ_PERSO) begin
                  data_src_in = scpch_pkg::SRC_PERSO;
                  data_cnt_in = perso_len_ff;
               end else if (ins == scpch_pkg::INS_READ_BALANCE) begin
                  data_src_in = scpch_pkg::SRC_BALANCE;
                  data_cnt_in = scpch_pkg::BALANCE_LEN[5:0];
               end else begin
                  phase_in  = scpch_pkg::PH_AMOUNT;
                  bc_in     = 6'd0;
                  has_sw_in = 1'b0;
               end
            end
         end
         scpch_pkg::ST_PCHK: begin
            // Last personalization byte: swap banks to commit.
            if (perso_done) begin
               bank_in      = !bank_ff;
               perso_len_in = p3[5:0];
               phase_in     = scpch_pkg::PH_HEADER;
               bc_in        = 6'd0;
               sw1_in       = scpch_pkg::SW1_OK;
               sw2_in       = scpch_pkg::SW2_NONE;
            end
         end
         scpch_pkg::ST_ACHK: begin
            // Carry on credit or borrow on debit refuses the update.
            if (!alu_res[16]) begin
               balance_in = alu_res[15:0];
            end
            sw1_in   = alu_res[16] ? scpch_pkg::SW1_REFUSED : scpch_pkg::SW1_OK;
            sw2_in   = scpch_pkg::SW2_NONE;
            phase_in = scpch_pkg::PH_HEADER;
            bc_in    = 6'd0;
         end
         scpch_pkg::ST_ATR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = scpch_pkg::atr_byte(emit_idx_ff[3:0]);
               rsp_last_in  = (emit_idx_ff == scpch_pkg::ATR_LAST);
               emit_idx_in  = emit_inc;
            end
         end
         scpch_pkg::ST_PROC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = ins;
               rsp_last_in  = (data_cnt_ff == 6'd0) && !has_sw_ff;
            end
         end
         scpch_pkg::ST_FETCH: begin
            mem_rd_en = 1'b1;
         end
         scpch_pkg::ST_DATA: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = data_byte;
               rsp_last_in  = data_last && !has_sw_ff;
               emit_idx_in  = emit_inc;
            end
         end
         scpch_pkg::ST_SW1: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = sw1_ff;
               rsp_last_in  = 1'b0;
            end
         end
         scpch_pkg::ST_SW2: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = sw2_ff;
               rsp_last_in  = 1'b1;
            end
         end
         default: begin
            rsp_last_in = rsp_last_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scpch_pkg::ST_IDLE;
         phase_ff     <= scpch_pkg::PH_HEADER;
         bc_ff        <= 6'd0;
         hdr_ff       <= '{default: 8'h00};
         amount_low_ff <= 8'h00;
         balance_ff   <= 16'd0;
         perso_len_ff <= 6'd0;
         bank_ff      <= 1'b0;
         class_ff     <= scpch_pkg::CLASS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         bc_ff        <= bc_in;
         hdr_ff       <= hdr_in;
         amount_low_ff <= amount_low_in;
         balance_ff   <= balance_in;
         perso_len_ff <= perso_len_in;
         bank_ff      <= bank_in;
         class_ff     <= class_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      emit_idx_ff <= emit_idx_in;
      data_cnt_ff <= data_cnt_in;
      data_src_ff <= data_src_in;
      has_sw_ff   <= has_sw_in;
      sw1_ff      <= sw1_in;
      sw2_ff      <= sw2_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.tx_byte     = rsp_byte_ff;
   assign rsp_chan.last_of_run = rsp_last_ff;

   // Shared arithmetic unit.
   scpch_alu u_alu (
      .clock   (clock),
      .alu_req (alu_req),
      .alu_res (alu_res)
   );

   // Personalization banks.
   scpch_perso_mem #(
      .ADDR_W (MEM_AW)
   ) u_perso_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req_chan.rx_byte),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

`ifndef SYNTHESIS
   // The balance only moves in the arithmetic check state.
   a_balance_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff != scpch_pkg::ST_ACHK) |=> $stable(balance_ff))
      else $error("balance changed outside a credit or debit");

   // A bank swap only happens when a personalization write completes.
   a_bank_commit: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == scpch_pkg::ST_CHK || state_ff == scpch_pkg::ST_PCHK)
      |=> ($stable(bank_ff) && $stable(perso_len_ff)))
      else $error("personalization committed outside a completed write");

   // While collecting personalization data, the count stays below p3.
   a_perso_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scpch_pkg::ST_IDLE && phase_ff == scpch_pkg::PH_PERSO)
      |-> ({2'b00, bc_ff} < hdr_ff[4]))
      else $error("personalization count reached p3 without commit");

   // Header collection never points past the fifth byte.
   a_header_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scpch_pkg::ST_IDLE && phase_ff == scpch_pkg::PH_HEADER)
      |-> (bc_ff < 6'd5))
      else $error("header byte count out of range");
`endif

endmodule
